// ===== design/rhm_pkg.sv =====
package rhm_pkg;

   // Default sizing handed to the top-level parameters.
   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int HASH_WIDTH_DEFAULT  = 32;

   // Polynomial base and the bias that maps a byte to its symbol value.
   localparam int HASH_BASE   = 31;
   localparam int SYMBOL_BIAS = 96;

   // Item command codes.
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_PATTERN = 2'd1;
   localparam logic [1:0] CMD_TEXT    = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic execute;
      logic multiply;
      logic roll;
      logic compare;
      logic load_result;
   } dp_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] command;
      logic       pattern_empty;
      logic       window_full;
   } dp_status_type;

endpackage

// ===== design/rhm_ram.sv =====
module rhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                       read_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

endmodule

// ===== design/rhm_datapath.sv =====
module rhm_datapath #(
   parameter int PATTERN_MAX = rhm_pkg::PATTERN_MAX_DEFAULT,
   parameter int HASH_WIDTH  = rhm_pkg::HASH_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rhm_pkg::dp_ctrl_type  ctrl,
   output rhm_pkg::dp_status_type status,
   input  logic [1:0]            item_command,
   input  logic [7:0]            item_symbol,
   output logic [7:0]            result_data
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int PTR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int W     = HASH_WIDTH;

   // Latched item.
   logic [1:0]       command_ff, command_in;
   logic [7:0]       symbol_ff, symbol_in;

   // Hash state.
   logic [W-1:0]     pattern_hash_ff, pattern_hash_in;
   logic [LEN_W-1:0] pattern_length_ff, pattern_length_in;
   logic [W-1:0]     top_power_ff, top_power_in;
   logic [W-1:0]     window_hash_ff, window_hash_in;
   logic [LEN_W-1:0] text_count_ff, text_count_in;
   logic [PTR_W-1:0] ring_pointer_ff, ring_pointer_in;
   logic             found_ff, found_in;

   // Per-item results and the product of the removal step.
   logic             match_ff, match_in;
   logic             overflow_ff, overflow_in;
   logic [W-1:0]     product_ff, product_in;
   logic [7:0]       result_ff, result_in;

   // Ring memory signals.
   logic             ring_write;
   logic [7:0]       ring_read_data;

   // Derived values.
   logic signed [8:0]   symbol_d9;
   logic [W-1:0]        symbol_value;
   logic signed [8:0]   old_d9;
   logic signed [W+9:0] product_full;
   logic [LEN_W-1:0]    pointer_inc;
   logic [PTR_W-1:0]    pointer_next;
   logic                pattern_full;
   logic                pattern_empty;
   logic                window_full;
   logic [W-1:0]        removed_hash;

   // Symbol values are the byte minus the bias, sign-extended so they wrap.
   assign symbol_d9    = $signed({1'b0, symbol_ff}) - 9'(rhm_pkg::SYMBOL_BIAS);
   assign symbol_value = {{(W-9){symbol_d9[8]}}, symbol_d9};
   assign old_d9       = $signed({1'b0, ring_read_data}) - 9'(rhm_pkg::SYMBOL_BIAS);

   // Top power times the outgoing symbol; only the low hash bits are kept.
   assign product_full = $signed({1'b0, top_power_ff}) * old_d9;

   // Ring pointer advances and wraps at the pattern length.
   assign pointer_inc  = LEN_W'(ring_pointer_ff) + LEN_W'(1);
   assign pointer_next = (pointer_inc == pattern_length_ff) ? '0 : pointer_inc[PTR_W-1:0];

   assign pattern_full  = (pattern_length_ff == LEN_W'(PATTERN_MAX));
   assign pattern_empty = (pattern_length_ff == '0);
   assign window_full   = (text_count_ff >= pattern_length_ff);
   assign removed_hash  = window_hash_ff - product_ff;

   assign status.command       = command_ff;
   assign status.pattern_empty = pattern_empty;
   assign status.window_full   = window_full;

   // Next-state logic for every step the controller issues.
   always_comb begin
      command_in        = command_ff;
      symbol_in         = symbol_ff;
      pattern_hash_in   = pattern_hash_ff;
      pattern_length_in = pattern_length_ff;
      top_power_in      = top_power_ff;
      window_hash_in    = window_hash_ff;
      text_count_in     = text_count_ff;
      ring_pointer_in   = ring_pointer_ff;
      found_in          = found_ff;
      match_in          = match_ff;
      overflow_in       = overflow_ff;
      product_in        = product_ff;
      result_in         = result_ff;
      ring_write        = 1'b0;

      if (ctrl.take_item) begin
         command_in = item_command;
         symbol_in  = item_symbol;
      end

      if (ctrl.execute) begin
         match_in    = 1'b0;
         overflow_in = 1'b0;
         unique case (command_ff)
            rhm_pkg::CMD_CLEAR: begin
               pattern_hash_in   = '0;
               pattern_length_in = '0;
               top_power_in      = W'(1);
               window_hash_in    = '0;
               text_count_in     = '0;
               ring_pointer_in   = '0;
               found_in          = 1'b0;
            end
            rhm_pkg::CMD_PATTERN: begin
               if (pattern_full) begin
                  overflow_in = 1'b1;
               end else begin
                  pattern_hash_in = W'(pattern_hash_ff * W'(rhm_pkg::HASH_BASE)) + symbol_value;
                  if (!pattern_empty) begin
                     top_power_in = W'(top_power_ff * W'(rhm_pkg::HASH_BASE));
                  end
                  pattern_length_in = pattern_length_ff + LEN_W'(1);
                  window_hash_in    = '0;
                  text_count_in     = '0;
                  ring_pointer_in   = '0;
                  found_in          = 1'b0;
               end
            end
            rhm_pkg::CMD_RESTART: begin
               window_hash_in  = '0;
               text_count_in   = '0;
               ring_pointer_in = '0;
               found_in        = 1'b0;
            end
            rhm_pkg::CMD_TEXT: begin
               if (pattern_empty) begin
                  match_in = 1'b1;
                  found_in = 1'b1;
               end else if (!window_full) begin
                  // Window still filling: no byte leaves the hash.
                  window_hash_in  = W'(window_hash_ff * W'(rhm_pkg::HASH_BASE)) + symbol_value;
                  text_count_in   = text_count_ff + LEN_W'(1);
                  ring_pointer_in = pointer_next;
                  ring_write      = 1'b1;
               end
            end
         endcase
      end

      // The outgoing byte is on the read port now; store the new one in its place.
      if (ctrl.multiply) begin
         product_in = product_full[W-1:0];
         ring_write = 1'b1;
      end

      if (ctrl.roll) begin
         window_hash_in  = W'(removed_hash * W'(rhm_pkg::HASH_BASE)) + symbol_value;
         ring_pointer_in = pointer_next;
      end

      if (ctrl.compare) begin
         match_in = window_full && (window_hash_ff == pattern_hash_ff);
         if (window_full && (window_hash_ff == pattern_hash_ff)) begin
            found_in = 1'b1;
         end
      end

      if (ctrl.load_result) begin
         result_in = {5'b0, overflow_ff, found_ff, match_ff};
      end
   end

   // Control and hash state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_hash_ff   <= '0;
         pattern_length_ff <= '0;
         top_power_ff      <= W'(1);
         window_hash_ff    <= '0;
         text_count_ff     <= '0;
         ring_pointer_ff   <= '0;
         found_ff          <= 1'b0;
         match_ff          <= 1'b0;
         overflow_ff       <= 1'b0;
      end else begin
         pattern_hash_ff   <= pattern_hash_in;
         pattern_length_ff <= pattern_length_in;
         top_power_ff      <= top_power_in;
         window_hash_ff    <= window_hash_in;
         text_count_ff     <= text_count_in;
         ring_pointer_ff   <= ring_pointer_in;
         found_ff          <= found_in;
         match_ff          <= match_in;
         overflow_ff       <= overflow_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      command_ff <= command_in;
      symbol_ff  <= symbol_in;
      product_ff <= product_in;
      result_ff  <= result_in;
   end

   assign result_data = result_ff;

   // Window ring: one entry per pattern byte.
   rhm_ram #(
      .WIDTH (8),
      .DEPTH (PATTERN_MAX)
   ) u_ring (
      .clock         (clock),
      .write_enable  (ring_write),
      .write_address (ring_pointer_ff),
      .write_data    (symbol_ff),
      .read_address  (ring_pointer_ff),
      .read_data_ff  (ring_read_data)
   );

   // The ring pointer always addresses a byte of the current window.
   a_pointer_in_window: assert property (@(posedge clock) disable iff (reset)
      (pattern_length_ff != '0) |-> (LEN_W'(ring_pointer_ff) < pattern_length_ff))
      else $error("ring pointer beyond pattern length");

   // The text count saturates at the pattern length.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      text_count_ff <= pattern_length_ff)
      else $error("text count exceeds pattern length");

   // The top power stays at one until a second pattern byte arrives.
   a_top_power_one: assert property (@(posedge clock) disable iff (reset)
      (pattern_length_ff <= LEN_W'(1)) |-> (top_power_ff == W'(1)))
      else $error("top power changed for a short pattern");

endmodule

// ===== design/rhm_controller.sv =====
module rhm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output rhm_pkg::dp_ctrl_type   ctrl,
   input  rhm_pkg::dp_status_type status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ROLL = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Step sequencing for one item.
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.take_item = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.execute = 1'b1;
            priority if (status.command == rhm_pkg::CMD_TEXT && !status.pattern_empty
                         && status.window_full) begin
               state_in = ST_MUL;
            end else if (status.command == rhm_pkg::CMD_TEXT && !status.pattern_empty) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            ctrl.multiply = 1'b1;
            state_in      = ST_ROLL;
         end
         ST_ROLL: begin
            ctrl.roll = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            ctrl.compare = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               ctrl.load_result = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register holds a result until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.load_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_result |-> slot_free)
      else $error("result loaded over a pending result");

   // An accepted item always starts execution next.
   a_accept_executes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted item did not execute");

   // The output turns valid only after a result load.
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.load_result))
      else $error("output valid without a result load");

endmodule

// ===== design/rolling_hash_substring_match_core.sv =====
// Channel  Direction  Payload
// req_     in         tuser[1:0] command; tdata[7:0] symbol
// rsp_     out        tdata[0] match_here, [1] found, [2] pattern_overflow
//
// Clear, restart, pattern bytes and text bytes on an empty pattern pass execute and done.
// A text byte while the window fills adds a compare step; once full it adds, in turn,
// the ring read with the top-power multiply, the rolling update and the compare.
// Reset is synchronous, active high; the ring memory needs no clearing pass.
// One result may wait in the output register while the next item is accepted.
module rolling_hash_substring_match_core #(
   parameter int PATTERN_MAX = rhm_pkg::PATTERN_MAX_DEFAULT,
   parameter int HASH_WIDTH  = rhm_pkg::HASH_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] match_here, [1] found, [2] pattern_overflow
);

   rhm_pkg::dp_ctrl_type   ctrl;
   rhm_pkg::dp_status_type status;

   // Step sequencer and output handshake.
   rhm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl),
      .status     (status)
   );

   // Hash state, ring memory and result register.
   rhm_datapath #(
      .PATTERN_MAX (PATTERN_MAX),
      .HASH_WIDTH  (HASH_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .item_command (req_tuser),
      .item_symbol  (req_tdata),
      .result_data  (rsp_tdata)
   );

endmodule
